FILE: rtl/zbuffer_span_fill_blend_assert.svh
// Assertion macros for the z-buffer span filler
`ifndef ZBUFFER_SPAN_FILL_BLEND_ASSERT_SVH
`define ZBUFFER_SPAN_FILL_BLEND_ASSERT_SVH
// implication checked every clock edge outside reset
`define ZSF_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// implication whose consequent is checked in the next cycle
`define ZSF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: rtl/zsf_pkg.sv
// Package for the z-buffer span filler: codes, sizes, state type, blend helpers
package zsf_pkg;
	localparam int XW = 8;
	localparam int YW = 8;
	localparam int AW = XW + YW;
	localparam logic [31:0] DEPTH_FAR = 32'h8000_0000;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_DRAW = 2'd1,
		OP_RDZ = 2'd2,
		OP_RDC = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_RD,
		ST_RMW,
		ST_WB,
		ST_DONE
	} state_t;

	// x / 255 for x <= 65025
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		begin
			t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
			div255 = t[15:8];
		end
	endfunction
endpackage

FILE: rtl/zbuffer_span_fill_blend.sv
// Top level of the z-buffer span filler with source-over blending
//
// channel | signals                                       | handshake
// command | operation row x_first x_last depth_* fill_*  | start && !busy
//         | faded fade_start fade_step depth_write        |
// result  | read_data pixels_drawn                        | done, one cycle
//
// Draw: each pixel is read, blended and written back before the next.
// Clear: one entry a cycle. Reads pass the read state, then done.
// The pixel rate is set by the single read-modify-write on both memories.
// arst_n clears control; memory contents stay undefined until a clear.
// The receiver cannot stall; done pulses for one cycle.
module zbuffer_span_fill_blend (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] operation,
	input logic [7:0] row,
	input logic [7:0] x_first,
	input logic [7:0] x_last,
	input logic signed [31:0] depth_start,
	input logic signed [31:0] depth_step,
	input logic [31:0] fill_colour,
	input logic faded,
	input logic signed [23:0] fade_start,
	input logic signed [23:0] fade_step,
	input logic depth_write,
	output logic done,
	output logic [31:0] read_data,
	output logic [8:0] pixels_drawn
);
	import zsf_pkg::*;

	logic [31:0] cmem [0:(1 << AW) - 1];
	logic [31:0] zmem [0:(1 << AW) - 1];

	state_t st_q, st_d;
	op_t op_q;
	logic [YW-1:0] row_q;
	logic [XW:0] x_q, xl_q;
	logic [AW:0] clr_q;
	logic signed [31:0] z_q, dz_q;
	logic signed [33:0] f_q;
	logic signed [23:0] df_q;
	logic [31:0] fill_q;
	logic faded_q, dw_q;
	logic [8:0] cnt_q;
	logic [31:0] crd_q, zrd_q;
	logic [31:0] cwr_q;
	logic pass_q;
	logic [31:0] rdat_q;
	logic [8:0] pix_q;
	logic done_q;
	logic fade_ok_q;
	logic [7:0] a_eff_q;

	logic [AW-1:0] addr;
	logic [7:0] alpha;
	logic signed [43:0] prod;
	logic [7:0] a_eff;
	logic fade_ok;
	logic pix_ok;
	logic [31:0] blended;
	logic [7:0] ia;

	assign addr = {row_q, x_q[XW-1:0]};
	assign alpha = fill_q[31:24];

	always_ff @(posedge clk) begin
		if (st_q == ST_CLEAR) begin
			cmem[clr_q[AW-1:0]] <= fill_q;
			zmem[clr_q[AW-1:0]] <= DEPTH_FAR;
		end else if (st_q == ST_WB && pass_q) begin
			cmem[addr] <= cwr_q;
			if (dw_q)
				zmem[addr] <= z_q;
		end
		crd_q <= cmem[addr];
		zrd_q <= zmem[addr];
	end

	// fade alpha is settled during the read cycle
	always_comb begin
		prod = 44'($signed({1'b0, alpha})) * 44'(f_q);
		fade_ok = 1'b1;
		a_eff = alpha;
		if (faded_q) begin
			if (prod <= 0 || (prod >>> 16) <= 0)
				fade_ok = 1'b0;
			else if ((prod >>> 16) > 255)
				a_eff = 8'd255;
			else
				a_eff = prod[23:16];
		end
	end

	always_comb begin
		pix_ok = fade_ok_q;
		if ($signed(z_q) <= $signed(zrd_q))
			pix_ok = 1'b0;
		ia = 8'd255 - a_eff_q;
		blended[31:24] = a_eff_q + div255({8'd0, crd_q[31:24]} * {8'd0, ia});
		blended[23:16] = div255({8'd0, fill_q[23:16]} * {8'd0, a_eff_q})
			+ div255({8'd0, crd_q[23:16]} * {8'd0, ia});
		blended[15:8] = div255({8'd0, fill_q[15:8]} * {8'd0, a_eff_q})
			+ div255({8'd0, crd_q[15:8]} * {8'd0, ia});
		blended[7:0] = div255({8'd0, fill_q[7:0]} * {8'd0, a_eff_q})
			+ div255({8'd0, crd_q[7:0]} * {8'd0, ia});
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (start) begin
					case (op_t'(operation))
						OP_CLEAR: st_d = ST_CLEAR;
						OP_DRAW: begin
							if (fill_colour[31:24] == 8'd0 || x_last < x_first)
								st_d = ST_DONE;
							else
								st_d = ST_RD;
						end
						default: st_d = ST_RD;
					endcase
				end
			end
			ST_CLEAR: if (clr_q[AW]) st_d = ST_DONE;
			ST_RD: st_d = (op_q == OP_DRAW) ? ST_RMW : ST_DONE;
			ST_RMW: st_d = ST_WB;
			ST_WB: st_d = (x_q == xl_q) ? ST_DONE : ST_RD;
			ST_DONE: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy = (st_q != ST_IDLE);
		done = done_q;
		read_data = rdat_q;
		pixels_drawn = pix_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			done_q <= 1'b0;
			cnt_q <= '0;
			clr_q <= '0;
		end else begin
			st_q <= st_d;
			done_q <= (st_q == ST_DONE);
			if (st_q == ST_IDLE) begin
				cnt_q <= '0;
				clr_q <= '0;
			end
			if (st_q == ST_CLEAR)
				clr_q <= clr_q + 1'b1;
			if (st_q == ST_RMW && pix_ok)
				cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && start) begin
			op_q <= op_t'(operation);
			row_q <= row;
			x_q <= {1'b0, x_first};
			xl_q <= {1'b0, x_last};
			z_q <= depth_start;
			dz_q <= depth_step;
			f_q <= 34'(fade_start);
			df_q <= fade_step;
			fill_q <= fill_colour;
			faded_q <= faded;
			dw_q <= depth_write;
		end
		if (st_q == ST_RD) begin
			fade_ok_q <= fade_ok;
			a_eff_q <= a_eff;
		end
		if (st_q == ST_RMW) begin
			pass_q <= pix_ok;
			cwr_q <= (!faded_q && alpha == 8'd255) ? fill_q : blended;
		end
		if (st_q == ST_WB && x_q != xl_q) begin
			x_q <= x_q + 1'b1;
			z_q <= z_q + dz_q;
			f_q <= f_q + 34'(df_q);
		end
		if (st_q == ST_DONE) begin
			case (op_q)
				OP_RDZ: rdat_q <= zrd_q;
				OP_RDC: rdat_q <= crd_q;
				default: rdat_q <= '0;
			endcase
			pix_q <= (op_q == OP_DRAW) ? cnt_q : 9'd0;
		end
	end

	`include "zbuffer_span_fill_blend_assert.svh"

	`ZSF_ASSERT_IMPL(a_done_idle, done, !busy, "done while busy")
	`ZSF_ASSERT_NEXT(a_start_busy, start && !busy, busy, "start not taken")
	`ZSF_ASSERT_IMPL(a_cnt_range, busy, cnt_q <= 9'd256, "pixel count overflow")
	`ZSF_ASSERT_NEXT(a_done_pulse, done, !done, "done longer than one cycle")
endmodule
